@@ rtl/rab_pkg.sv @@
// Shared types, constants and the modular inverse table for the recurrent affine byte cipher.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rab_pkg;

    // Alphabet base: a symbol's position is its byte value minus this, modulo 256.
    localparam logic [7:0] ALPHA_BASE = 8'd65;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIRECTION     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MULT_FIRST    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MULT_SECOND   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_FIRST  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_SECOND = 3'd4;

    // Direction codes.
    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    // One accepted input transaction as it travels through the queue.
    typedef struct packed {
        logic [7:0] symbol;
        logic       start;
    } t_item;

    // Seed keys as held by the configuration registers, with their inverses.
    typedef struct packed {
        logic       direction;
        logic [7:0] mult_first;
        logic [7:0] mult_second;
        logic [7:0] offset_first;
        logic [7:0] offset_second;
        logic [7:0] inv_first;
        logic [7:0] inv_second;
    } t_keys;

    // Queue status seen by the top level.
    typedef struct packed {
        logic push;
        logic full;
        logic empty;
    } t_queue_status;

    typedef logic [7:0] t_inv_table [256];

    // Inverse modulo 256 of every odd byte, built at elaboration by Newton
    // iteration (3, 6, 12 then 24 correct bits). Even entries are meaningless.
    function automatic t_inv_table build_inv_table();
        t_inv_table tbl;
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] ax;
        for (int i = 0; i < 256; i++) begin
            a = 8'(i);
            x = a;
            for (int k = 0; k < 3; k++) begin
                ax = 8'(a * x);
                x  = 8'(x * 8'(8'd2 - ax));
            end
            tbl[i] = x;
        end
        return tbl;
    endfunction

    localparam t_inv_table INV_TABLE = build_inv_table();

endpackage

`default_nettype wire

@@ rtl/rab_front.sv @@
// Front end of the recurrent affine byte cipher: accepts transactions, drops them when a
// seed multiplier is even, and queues the rest for the back end. Depends on rab_pkg.
`default_nettype none

module rab_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire rab_pkg::t_item     i_item,
    input  wire                     i_keys_odd,
    input  wire                     i_pop,
    output logic                    o_head_valid,
    output rab_pkg::t_item          o_head,
    output rab_pkg::t_queue_status  o_status
);
    import rab_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    t_item           r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            push;
    logic            full;
    logic            empty;

    assign full  = (r_count == FULL_CNT);
    assign empty = (r_count == '0);

    // A transaction with an even seed is taken and discarded.
    assign o_ready = !full;
    assign push    = i_valid && !full && i_keys_odd;

    assign o_head_valid = !empty;
    assign o_head       = r_mem[r_rd_ptr];
    assign o_status     = '{push: push, full: full, empty: empty};

    always_comb begin
        n_count = r_count;
        case ({push, i_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/rab_back.sv @@
// Back end of the recurrent affine byte cipher: runs the key schedule, applies the affine
// map or its inverse, and holds the result in an output register. Depends on rab_pkg.
`default_nettype none

module rab_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire rab_pkg::t_keys i_keys,
    input  wire                 i_head_valid,
    input  wire rab_pkg::t_item i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [7:0]          o_symbol
);
    import rab_pkg::*;

    logic [7:0] r_mult_now;
    logic [7:0] r_mult_next;
    logic [7:0] r_offset_now;
    logic [7:0] r_offset_next;
    logic [7:0] r_inverse_now;
    logic [7:0] r_inverse_next;
    logic       r_out_valid;
    logic [7:0] r_out_symbol;

    logic [7:0] mult_a;
    logic [7:0] mult_b;
    logic [7:0] offset_a;
    logic [7:0] offset_b;
    logic [7:0] inverse_a;
    logic [7:0] inverse_b;
    logic [7:0] pos;
    logic [7:0] res;
    logic       step;

    assign step  = i_head_valid && (!r_out_valid || i_ready);
    assign o_pop = step;

    // A message start reloads the schedule from the seeds for this very byte.
    assign mult_a    = i_head.start ? i_keys.mult_first    : r_mult_now;
    assign mult_b    = i_head.start ? i_keys.mult_second   : r_mult_next;
    assign offset_a  = i_head.start ? i_keys.offset_first  : r_offset_now;
    assign offset_b  = i_head.start ? i_keys.offset_second : r_offset_next;
    assign inverse_a = i_head.start ? i_keys.inv_first     : r_inverse_now;
    assign inverse_b = i_head.start ? i_keys.inv_second    : r_inverse_next;

    assign pos = i_head.symbol - ALPHA_BASE;

    always_comb begin
        if (i_keys.direction == DIR_DECRYPT) begin
            res = 8'(8'(pos - offset_a) * inverse_a);
        end else begin
            res = 8'(8'(pos * mult_a) + offset_a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult_now     <= '0;
            r_mult_next    <= '0;
            r_offset_now   <= '0;
            r_offset_next  <= '0;
            r_inverse_now  <= '0;
            r_inverse_next <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (step) begin
                r_mult_now     <= mult_b;
                r_mult_next    <= 8'(mult_a * mult_b);
                r_offset_now   <= offset_b;
                r_offset_next  <= 8'(offset_a + offset_b);
                r_inverse_now  <= inverse_b;
                r_inverse_next <= 8'(inverse_a * inverse_b);
                r_out_valid    <= 1'b1;
            end else if (i_ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_symbol <= res + ALPHA_BASE;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_symbol = r_out_symbol;

endmodule

`default_nettype wire

@@ rtl/recurrent_affine_byte_cipher.sv @@
// Top level of the recurrent affine byte cipher: configuration registers, front end with
// its queue, and back end. Depends on rab_pkg, rab_front and rab_back.
`default_nettype none

// The block enciphers or deciphers a byte stream with a recurrent affine cipher modulo 256.
// Each byte's position is its value minus 'A'; encryption gives pos*a+b and decryption
// (pos-b)*inv(a), both mapped back by adding 'A'. The multipliers, offsets and inverses
// follow a Fibonacci-like schedule seeded from the configuration registers, and a transaction
// with message_start set reloads the schedule. When either seed multiplier is even, input
// transactions are accepted and silently dropped. The block takes one transaction per clock
// cycle while its queue is not full. An accepted transaction is written into the queue, and
// the back end then reads it from the queue head and registers its result once the output
// register is free or being taken. That step is bounded by the result path, a subtract, an
// 8 by 8 multiply and two adds, which runs alongside the schedule update and its two 8 by 8
// multiplies. Input is refused only when the two-entry queue is full, which happens only
// while the consumer holds off a waiting result.
// Configuration writes take effect at once and are only to be made while no transaction is
// in flight.
module recurrent_affine_byte_cipher #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire  [7:0]                       i_symbol_in,
    input  wire                              i_message_start,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic [7:0]                       o_symbol_out,
    input  wire                              i_cfg_we,
    input  wire  [rab_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire  [7:0]                       i_cfg_wdata
);
    import rab_pkg::*;

    // Configuration registers. The inverse of each seed multiplier is looked up
    // when the seed is written, so the back end never waits for it.
    logic       r_direction;
    logic [7:0] r_mult_first;
    logic [7:0] r_mult_second;
    logic [7:0] r_offset_first;
    logic [7:0] r_offset_second;
    logic [7:0] r_inv_first;
    logic [7:0] r_inv_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction     <= DIR_ENCRYPT;
            r_mult_first    <= 8'd1;
            r_mult_second   <= 8'd1;
            r_offset_first  <= 8'd0;
            r_offset_second <= 8'd0;
            r_inv_first     <= 8'd1;
            r_inv_second    <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DIRECTION: begin
                    r_direction <= i_cfg_wdata[0];
                end
                CFG_MULT_FIRST: begin
                    r_mult_first <= i_cfg_wdata;
                    r_inv_first  <= INV_TABLE[i_cfg_wdata];
                end
                CFG_MULT_SECOND: begin
                    r_mult_second <= i_cfg_wdata;
                    r_inv_second  <= INV_TABLE[i_cfg_wdata];
                end
                CFG_OFFSET_FIRST: begin
                    r_offset_first <= i_cfg_wdata;
                end
                CFG_OFFSET_SECOND: begin
                    r_offset_second <= i_cfg_wdata;
                end
                default: begin
                    // Writes to unused indexes are ignored.
                end
            endcase
        end
    end

    t_keys         keys;
    logic          keys_odd;
    t_item         in_item;
    t_item         head;
    logic          head_valid;
    logic          pop;
    t_queue_status q_status;

    assign keys = '{
        direction:     r_direction,
        mult_first:    r_mult_first,
        mult_second:   r_mult_second,
        offset_first:  r_offset_first,
        offset_second: r_offset_second,
        inv_first:     r_inv_first,
        inv_second:    r_inv_second
    };

    // Only odd multipliers are invertible modulo 256; with an even seed no output is produced.
    assign keys_odd = r_mult_first[0] && r_mult_second[0];

    assign in_item = '{symbol: i_symbol_in, start: i_message_start};

    rab_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (in_item),
        .i_keys_odd   (keys_odd),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head),
        .o_status     (q_status)
    );

    rab_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_keys       (keys),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_symbol     (o_symbol_out)
    );

    // A transaction only enters the queue when both seed multipliers are odd.
    a_push_needs_odd_seeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.push |-> keys_odd)
        else $error("transaction queued with an even seed multiplier");

    // The back end never takes a transaction from an empty queue.
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("back end popped an empty queue");

    // The queue cannot be empty and full at once.
    a_queue_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports empty and full together");

    // A result that is stalled by the consumer stays in the output register.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_symbol_out)))
        else $error("stalled result was lost or changed");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for recurrent_affine_byte_cipher: a directed table, then random
// messages under random idling, checked against a bit-accurate predictor of the cipher.
// Depends on rab_pkg and the RTL of the block; it needs no other file.

module testbench;

    import rab_pkg::*;

    // This margin covers a transaction that the block is still dropping when the last
    // expected result has already come out.
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int NUM_PHASES    = 14;
    localparam int PHASE_ITEMS   = 146;

    // A row of the directed table either writes a register or offers one transaction. Its
    // result is either typed in by hand or worked out by the predictor.
    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_LITERAL,
        ROW_MODEL
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [7:0]            data;
        logic                  first;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [7:0]            literal;
    } t_row;

    localparam int NUM_DIRECTED_ROWS = 35;

    // The block comes out of reset with identity seeds (multipliers 1, offsets 0) but with an
    // all-zero schedule, so until the first message start every byte enciphers to 'A'. Once a
    // message has started under the identity seeds, every byte maps to itself in both
    // directions. The later rows use extreme seeds and even multipliers, which silence the
    // block, and rewrite a seed in the middle of a message.
    t_row directed_rows [NUM_DIRECTED_ROWS] = '{
        '{ROW_LITERAL, 8'h00, 1'b0, CFG_DIRECTION,     8'h41},
        '{ROW_LITERAL, 8'hFF, 1'b0, CFG_DIRECTION,     8'h41},
        '{ROW_LITERAL, 8'h5A, 1'b0, CFG_DIRECTION,     8'h41},
        '{ROW_LITERAL, 8'h00, 1'b1, CFG_DIRECTION,     8'h00},
        '{ROW_LITERAL, 8'hFF, 1'b0, CFG_DIRECTION,     8'hFF},
        '{ROW_LITERAL, 8'h41, 1'b0, CFG_DIRECTION,     8'h41},
        '{ROW_WRITE,   8'h01, 1'b0, CFG_DIRECTION,     8'h00},
        '{ROW_LITERAL, 8'h80, 1'b1, CFG_DIRECTION,     8'h80},
        '{ROW_LITERAL, 8'h7F, 1'b0, CFG_DIRECTION,     8'h7F},
        '{ROW_WRITE,   8'hFF, 1'b0, CFG_MULT_FIRST,    8'h00},
        '{ROW_WRITE,   8'h03, 1'b0, CFG_MULT_SECOND,   8'h00},
        '{ROW_WRITE,   8'hFF, 1'b0, CFG_OFFSET_FIRST,  8'h00},
        '{ROW_WRITE,   8'h80, 1'b0, CFG_OFFSET_SECOND, 8'h00},
        '{ROW_MODEL,   8'hFF, 1'b1, CFG_DIRECTION,     8'h00},
        '{ROW_MODEL,   8'h00, 1'b0, CFG_DIRECTION,     8'h00},
        '{ROW_MODEL,   8'h41, 1'b0, CFG_DIRECTION,     8'h00},
        '{ROW_WRITE,   8'h00, 1'b0, CFG_DIRECTION,     8'h00},
        '{ROW_MODEL,   8'h00, 1'b1, CFG_DIRECTION,     8'h00},
        '{ROW_MODEL,   8'hFF, 1'b0, CFG_DIRECTION,     8'h00},
        '{ROW_MODEL,   8'h41, 1'b0, CFG_DIRECTION,     8'h00},
        '{ROW_MODEL,   8'h40, 1'b0, CFG_DIRECTION,     8'h00},
        '{ROW_WRITE,   8'h02, 1'b0, CFG_MULT_FIRST,    8'h00},
        '{ROW_MODEL,   8'h10, 1'b1, CFG_DIRECTION,     8'h00},
        '{ROW_MODEL,   8'h20, 1'b0, CFG_DIRECTION,     8'h00},
        '{ROW_WRITE,   8'h01, 1'b0, CFG_MULT_FIRST,    8'h00},
        '{ROW_WRITE,   8'hFE, 1'b0, CFG_MULT_SECOND,   8'h00},
        '{ROW_MODEL,   8'h30, 1'b1, CFG_DIRECTION,     8'h00},
        '{ROW_WRITE,   8'h01, 1'b0, CFG_MULT_SECOND,   8'h00},
        '{ROW_MODEL,   8'h31, 1'b0, CFG_DIRECTION,     8'h00},
        '{ROW_WRITE,   8'hC3, 1'b0, CFG_MULT_FIRST,    8'h00},
        '{ROW_MODEL,   8'h32, 1'b0, CFG_DIRECTION,     8'h00},
        '{ROW_MODEL,   8'h33, 1'b1, CFG_DIRECTION,     8'h00},
        '{ROW_MODEL,   8'h34, 1'b0, CFG_DIRECTION,     8'h00},
        '{ROW_WRITE,   8'h00, 1'b0, CFG_MULT_FIRST,    8'h00},
        '{ROW_MODEL,   8'hAA, 1'b0, CFG_DIRECTION,     8'h00}
    };

    // Every input of the block holds a known value from time zero.
    logic                  i_clk;
    logic                  i_rst_n         = 1'b0;
    logic                  i_valid         = 1'b0;
    logic [7:0]            i_symbol_in     = 8'h00;
    logic                  i_message_start = 1'b0;
    logic                  i_ready         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr      = CFG_DIRECTION;
    logic [7:0]            i_cfg_wdata     = 8'h00;
    wire                   o_ready;
    wire                   o_valid;
    wire  [7:0]            o_symbol_out;

    // A hand-typed result travels alongside the transaction that it belongs to.
    bit                    literal_armed = 1'b0;
    logic [7:0]            literal_symbol = 8'h00;

    // Idling limits of the two sides, changed from phase to phase.
    int                    gap_max  = 3;
    int                    stall_max = 3;
    bit                    long_hold_wanted = 1'b0;

    // Mirror of the configuration registers, starting from their reset values.
    logic                  cfg_dir         = DIR_ENCRYPT;
    logic [7:0]            cfg_mult_first  = 8'd1;
    logic [7:0]            cfg_mult_second = 8'd1;
    logic [7:0]            cfg_ofs_first   = 8'd0;
    logic [7:0]            cfg_ofs_second  = 8'd0;

    // Key schedule: the pair for the current byte and the pair for the byte after it.
    logic [7:0]            sched_mult_cur = 8'd0;
    logic [7:0]            sched_mult_nxt = 8'd0;
    logic [7:0]            sched_ofs_cur  = 8'd0;
    logic [7:0]            sched_ofs_nxt  = 8'd0;
    logic [7:0]            sched_inv_cur  = 8'd0;
    logic [7:0]            sched_inv_nxt  = 8'd0;

    logic [7:0]            expected_symbols [$];
    int                    mismatch_count = 0;

    recurrent_affine_byte_cipher u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_symbol_in     (i_symbol_in),
        .i_message_start (i_message_start),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_symbol_out    (o_symbol_out),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The inverse of an odd byte, found by plain search rather than by iteration, so that
    // it shares nothing with the way the block builds its table.
    function automatic logic [7:0] odd_inverse(input logic [7:0] a);
        logic [7:0] prod;
        for (int x = 1; x < 256; x += 2) begin
            prod = a * 8'(x);
            if (prod == 8'd1) begin
                return 8'(x);
            end
        end
        return 8'd0;
    endfunction

    // Advances the cipher by one accepted byte. While either seed multiplier is even the
    // byte is swallowed and the schedule is left as it stands, even on a message start.
    task automatic cipher_step(input logic [7:0] sym, input logic first,
                               output bit produced, output logic [7:0] result);
        logic [7:0] pos;
        logic [7:0] val;
        logic [7:0] mult_new;
        logic [7:0] ofs_new;
        logic [7:0] inv_new;
        produced = 1'b0;
        result   = 8'h00;
        if (!cfg_mult_first[0] || !cfg_mult_second[0]) begin
            return;
        end
        if (first) begin
            sched_mult_cur = cfg_mult_first;
            sched_mult_nxt = cfg_mult_second;
            sched_ofs_cur  = cfg_ofs_first;
            sched_ofs_nxt  = cfg_ofs_second;
            sched_inv_cur  = odd_inverse(cfg_mult_first);
            sched_inv_nxt  = odd_inverse(cfg_mult_second);
        end
        // All arithmetic is eight bits wide, so it wraps modulo 256 by itself.
        pos = sym - ALPHA_BASE;
        if (cfg_dir == DIR_ENCRYPT) begin
            val = pos * sched_mult_cur + sched_ofs_cur;
        end else begin
            val = (pos - sched_ofs_cur) * sched_inv_cur;
        end
        result   = val + ALPHA_BASE;
        produced = 1'b1;
        mult_new = sched_mult_cur * sched_mult_nxt;
        ofs_new  = sched_ofs_cur + sched_ofs_nxt;
        inv_new  = sched_inv_cur * sched_inv_nxt;
        sched_mult_cur = sched_mult_nxt;
        sched_mult_nxt = mult_new;
        sched_ofs_cur  = sched_ofs_nxt;
        sched_ofs_nxt  = ofs_new;
        sched_inv_cur  = sched_inv_nxt;
        sched_inv_nxt  = inv_new;
    endtask

    // A random byte that lands on one of the corner values about one time in eight.
    function automatic logic [7:0] key_byte();
        logic [7:0] corners [6] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
        if ($urandom_range(0, 7) == 0) begin
            return corners[$urandom_range(0, 5)];
        end
        return 8'($urandom);
    endfunction

    // Offers one transaction after a random gap and returns in the time step of the clock
    // edge at which it is accepted, so that the next offer can follow with no gap at all.
    task automatic offer_symbol(input logic [7:0] sym, input logic first,
                                input bit use_literal, input logic [7:0] literal);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_symbol_in     <= sym;
        i_message_start <= first;
        literal_armed   <= use_literal;
        literal_symbol  <= literal;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Stops offering and waits until every expected result has been taken, then lets the
    // block finish with any transaction that it is still dropping.
    task automatic settle_block();
        i_valid <= 1'b0;
        while (expected_symbols.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write, followed by a wait with the enable low, which keeps the enable from
    // being lowered and raised again within the same time step when writes follow one another.
    task automatic write_register(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] value);
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result checking, the register mirror and prediction all happen here on the values that
    // the block itself samples at the edge. The output is checked before the input is
    // predicted, so a stray result can never be matched against a byte accepted at the
    // same edge.
    always @(posedge i_clk) begin : scoreboard
        logic [7:0] want;
        bit         produced;
        logic [7:0] predicted;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_symbols.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected transaction: symbol_out %02h, nothing expected",
                             o_symbol_out);
                end
            end else begin
                want = expected_symbols.pop_front();
                if (o_symbol_out !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: symbol_out expected %02h, got %02h",
                                 want, o_symbol_out);
                    end
                end
            end
        end
        if (i_rst_n && i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DIRECTION:     cfg_dir         = i_cfg_wdata[0];
                CFG_MULT_FIRST:    cfg_mult_first  = i_cfg_wdata;
                CFG_MULT_SECOND:   cfg_mult_second = i_cfg_wdata;
                CFG_OFFSET_FIRST:  cfg_ofs_first   = i_cfg_wdata;
                CFG_OFFSET_SECOND: cfg_ofs_second  = i_cfg_wdata;
                default: ;
            endcase
        end
        if (i_rst_n && i_valid && o_ready) begin
            cipher_step(i_symbol_in, i_message_start, produced, predicted);
            if (produced) begin
                expected_symbols.insert(expected_symbols.size(),
                                        literal_armed ? literal_symbol : predicted);
            end
        end
    end

    // Receiving side. Each result is preceded by a random stall; once, on request, the stall
    // is long enough for the block to fill up and refuse input.
    initial begin : result_sink
        int stall;
        forever begin
            stall = $urandom_range(0, stall_max);
            if (long_hold_wanted) begin
                stall = HOLD_CYCLES;
                long_hold_wanted = 1'b0;
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && o_valid));
        end
    end

    // Stimulus: reset, the directed table, then phases of random messages, each phase under
    // its own keys and its own idling pattern.
    initial begin : stimulus
        int   sent;
        int   msg_len;
        int   mode;
        logic first;
        bit   even_phase;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            case (directed_rows[r].kind)
                ROW_WRITE: begin
                    settle_block();
                    write_register(directed_rows[r].reg_idx, directed_rows[r].data);
                end
                ROW_LITERAL: begin
                    offer_symbol(directed_rows[r].data, directed_rows[r].first,
                                 1'b1, directed_rows[r].literal);
                end
                default: begin
                    offer_symbol(directed_rows[r].data, directed_rows[r].first,
                                 1'b0, 8'h00);
                end
            endcase
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // Keys change only once the block has gone quiet. Without a rewrite, a seed
            // change reaches the schedule only at the next message start, and a phase may
            // well open in the middle of the previous phase's message. An even multiplier
            // left over from a silent phase is always rewritten.
            settle_block();
            even_phase = (phase % 5 == 4);
            write_register(CFG_DIRECTION, 8'($urandom));
            if (phase == 0 || !cfg_mult_first[0] || $urandom_range(0, 3) != 0) begin
                write_register(CFG_MULT_FIRST, key_byte() | 8'h01);
            end
            if (phase == 0 || !cfg_mult_second[0] || $urandom_range(0, 3) != 0) begin
                write_register(CFG_MULT_SECOND, key_byte() | 8'h01);
            end
            if (phase == 0 || $urandom_range(0, 3) != 0) begin
                write_register(CFG_OFFSET_FIRST, key_byte());
            end
            if (phase == 0 || $urandom_range(0, 3) != 0) begin
                write_register(CFG_OFFSET_SECOND, key_byte());
            end
            if (even_phase) begin
                write_register($urandom_range(0, 1) ? CFG_MULT_FIRST : CFG_MULT_SECOND,
                               key_byte() & 8'hFE);
            end

            // Idling pattern: none at all, one side only, or both sides.
            mode      = $urandom_range(0, 3);
            gap_max   = (mode == 1 || mode == 3) ? 8 : 0;
            stall_max = (mode == 2 || mode == 3) ? 8 : 0;
            if (phase == 2) begin
                gap_max = 0;
                long_hold_wanted = 1'b1;
            end

            if (!cfg_mult_first[0] || !cfg_mult_second[0]) begin
                // An even seed multiplier silences the block: a short burst of noise only.
                repeat (12) offer_symbol(8'($urandom), 1'($urandom), 1'b0, 8'h00);
            end else begin
                // Mostly well-formed messages; now and then a start is dropped or stray.
                sent = 0;
                while (sent < PHASE_ITEMS) begin
                    msg_len = $urandom_range(1, 40);
                    for (int j = 0; j < msg_len && sent < PHASE_ITEMS; j++) begin
                        first = (j == 0);
                        if ($urandom_range(0, 19) == 0) begin
                            first = ~first;
                        end
                        offer_symbol(8'($urandom), first, 1'b0, 8'h00);
                        sent++;
                    end
                end
            end
        end

        settle_block();
        if (mismatch_count == 0 && expected_symbols.size() == 0) begin
            $display("[recurrent_affine_byte_cipher] OK");
        end else begin
            $display("[recurrent_affine_byte_cipher] ERROR");
        end
        $finish;
    end

    // Watchdog: several times the slowest correct run.
    initial begin : watchdog
        #1_000_000;
        $display("[recurrent_affine_byte_cipher] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/rab_pkg.sv
rtl/rab_front.sv
rtl/rab_back.sv
rtl/recurrent_affine_byte_cipher.sv
tb/sv/testbench.sv
